[sv/imtc_pkg.sv]
// Shared types, widths, register indexes and reset values for the INT8 MLP classifier.
`default_nettype none
package imtc_pkg;

    localparam int FEATURES = 6;
    localparam int HIDDEN   = 4;
    localparam int LOGITS   = 2;

    localparam int FEAT_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int PROD_W    = 16;   // int8 x int8
    localparam int HACC_W    = 18;   // bias*16 plus six products
    localparam int HID_W     = 17;   // hidden value after ReLU, always >= 0
    localparam int MPROD_W   = 26;   // int8 x hidden value
    localparam int LOGIT_W   = 27;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int HW_W      = FEATURES * FEAT_W;

    typedef logic signed [FEAT_W-1:0]  feat_t;
    typedef logic        [HID_W-1:0]   hid_t;
    typedef logic signed [LOGIT_W-1:0] logit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIDDEN0_W = 3'd0,
        REG_HIDDEN1_W = 3'd1,
        REG_HIDDEN2_W = 3'd2,
        REG_HIDDEN3_W = 3'd3,
        REG_HIDDEN_B  = 3'd4,
        REG_OUT_W     = 3'd5,
        REG_OUT_B     = 3'd6
    } reg_idx_t;

    localparam logic [HW_W-1:0] HIDDEN0_W_RST = 48'd8787553810444;
    localparam logic [HW_W-1:0] HIDDEN1_W_RST = 48'd278180904307706;
    localparam logic [HW_W-1:0] HIDDEN2_W_RST = 48'd276007366558212;
    localparam logic [HW_W-1:0] HIDDEN3_W_RST = 48'd14276622222327;
    localparam logic [31:0]     HIDDEN_B_RST  = 32'd196353;
    localparam logic [63:0]     OUT_W_RST     = 64'd503289322871847177;
    localparam logic [15:0]     OUT_B_RST     = 16'd256;

    // per-stage load strobes
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } lane_ctl_t;

    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } merge_ctl_t;

endpackage
`default_nettype wire

[sv/imtc_lane.sv]
// One hidden-unit lane: masked products, then bias add and ReLU.
`default_nettype none
module imtc_lane (
    input  wire logic                                          aclk,
    input  wire imtc_pkg::lane_ctl_t                           ctl,
    input  wire imtc_pkg::feat_t [imtc_pkg::FEATURES-1:0]      features,
    input  wire logic [imtc_pkg::COUNT_W-1:0]                  feature_count,
    input  wire logic [imtc_pkg::HW_W-1:0]                     weights,
    input  wire logic [imtc_pkg::FEAT_W-1:0]                   bias,
    output imtc_pkg::hid_t                                     hidden
);

    logic signed [imtc_pkg::PROD_W-1:0] prod_reg  [imtc_pkg::FEATURES];
    logic signed [imtc_pkg::PROD_W-1:0] prod_next [imtc_pkg::FEATURES];
    imtc_pkg::hid_t                     hid_reg;
    imtc_pkg::hid_t                     hid_next;
    logic signed [imtc_pkg::HACC_W-1:0] acc;

    // features at or past the count are dropped before the multiply
    always_comb begin
        for (int i = 0; i < imtc_pkg::FEATURES; i++) begin
            if ({1'b0, feature_count} > 4'(i)) begin
                prod_next[i] = $signed(weights[8*i +: 8]) * features[i];
            end else begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb begin
        acc = imtc_pkg::HACC_W'($signed(bias)) <<< 4;
        for (int i = 0; i < imtc_pkg::FEATURES; i++) begin
            acc = acc + imtc_pkg::HACC_W'(prod_reg[i]);
        end
        hid_next = (acc > 0) ? acc[imtc_pkg::HID_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_prod) begin
            prod_reg <= prod_next;
        end
        if (ctl.en_sum) begin
            hid_reg <= hid_next;
        end
    end

    assign hidden = hid_reg;

endmodule
`default_nettype wire

[sv/imtc_merge.sv]
// Output layer: hidden-by-weight products, logit sums and argmax.
`default_nettype none
module imtc_merge (
    input  wire logic                                      aclk,
    input  wire imtc_pkg::merge_ctl_t                      ctl,
    input  wire imtc_pkg::hid_t [imtc_pkg::HIDDEN-1:0]     hidden,
    input  wire logic [63:0]                               out_weights,
    input  wire logic [15:0]                               out_biases,
    output logic                                           action,
    output imtc_pkg::logit_t                               normal_logit,
    output imtc_pkg::logit_t                               anomaly_logit
);

    logic signed [imtc_pkg::MPROD_W-1:0] mp_reg  [imtc_pkg::LOGITS][imtc_pkg::HIDDEN];
    logic signed [imtc_pkg::MPROD_W-1:0] mp_next [imtc_pkg::LOGITS][imtc_pkg::HIDDEN];
    imtc_pkg::logit_t                    sum     [imtc_pkg::LOGITS];
    imtc_pkg::logit_t                    normal_reg, anomaly_reg;
    logic                                action_reg;

    always_comb begin
        for (int o = 0; o < imtc_pkg::LOGITS; o++) begin
            for (int h = 0; h < imtc_pkg::HIDDEN; h++) begin
                mp_next[o][h] = $signed(out_weights[32*o + 8*h +: 8])
                              * $signed({1'b0, hidden[h]});
            end
        end
    end

    always_comb begin
        for (int o = 0; o < imtc_pkg::LOGITS; o++) begin
            sum[o] = imtc_pkg::LOGIT_W'($signed(out_biases[8*o +: 8])) <<< 8;
            for (int h = 0; h < imtc_pkg::HIDDEN; h++) begin
                sum[o] = sum[o] + imtc_pkg::LOGIT_W'(mp_reg[o][h]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_prod) begin
            mp_reg <= mp_next;
        end
        if (ctl.en_sum) begin
            normal_reg  <= sum[0];
            anomaly_reg <= sum[1];
            action_reg  <= (sum[1] > sum[0]);   // tie goes to normal
        end
    end

    assign action        = action_reg;
    assign normal_logit  = normal_reg;
    assign anomaly_logit = anomaly_reg;

endmodule
`default_nettype wire

[sv/int8_mlp_two_class_classifier.sv]
// Top level: weight registers, four hidden lanes, output merge and pipeline control.
// Pipeline: four register stages, the first (lane products) loaded at the accepting edge; the
// word then moves through hidden values, output products and the result register (m_valid).
// Throughput: one word per cycle unless stalled; four lanes and merge stage fully pipelined.
// Back-pressure stalls only stages that hold data; bubbles are squeezed out.
// Reset (aresetn low, synchronous): pipeline emptied and weights restored to trained defaults.
// Configuration writes are always taken (cfg_ready high); unknown indexes are dropped.
`default_nettype none
module int8_mlp_two_class_classifier (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input words
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire imtc_pkg::feat_t                      s_feature_0,
    input  wire imtc_pkg::feat_t                      s_feature_1,
    input  wire imtc_pkg::feat_t                      s_feature_2,
    input  wire imtc_pkg::feat_t                      s_feature_3,
    input  wire imtc_pkg::feat_t                      s_feature_4,
    input  wire imtc_pkg::feat_t                      s_feature_5,
    input  wire logic [imtc_pkg::COUNT_W-1:0]         s_feature_count,
    // result words
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_action,
    output imtc_pkg::logit_t                          m_normal_logit,
    output imtc_pkg::logit_t                          m_anomaly_logit,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [imtc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [imtc_pkg::CFG_W-1:0]           cfg_data
);

    // ---------------------------------------------------------------
    // Weight and bias registers
    // ---------------------------------------------------------------
    logic [imtc_pkg::HW_W-1:0] hw_reg [imtc_pkg::HIDDEN];
    logic [31:0]               hb_reg;
    logic [63:0]               ow_reg;
    logic [15:0]               ob_reg;
    logic                      cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg[0] <= imtc_pkg::HIDDEN0_W_RST;
            hw_reg[1] <= imtc_pkg::HIDDEN1_W_RST;
            hw_reg[2] <= imtc_pkg::HIDDEN2_W_RST;
            hw_reg[3] <= imtc_pkg::HIDDEN3_W_RST;
            hb_reg    <= imtc_pkg::HIDDEN_B_RST;
            ow_reg    <= imtc_pkg::OUT_W_RST;
            ob_reg    <= imtc_pkg::OUT_B_RST;
        end else if (cfg_wr) begin
            case (imtc_pkg::reg_idx_t'(cfg_index))
                imtc_pkg::REG_HIDDEN0_W: begin
                    hw_reg[0] <= cfg_data[imtc_pkg::HW_W-1:0];
                end
                imtc_pkg::REG_HIDDEN1_W: begin
                    hw_reg[1] <= cfg_data[imtc_pkg::HW_W-1:0];
                end
                imtc_pkg::REG_HIDDEN2_W: begin
                    hw_reg[2] <= cfg_data[imtc_pkg::HW_W-1:0];
                end
                imtc_pkg::REG_HIDDEN3_W: begin
                    hw_reg[3] <= cfg_data[imtc_pkg::HW_W-1:0];
                end
                imtc_pkg::REG_HIDDEN_B: begin
                    hb_reg <= cfg_data[31:0];
                end
                imtc_pkg::REG_OUT_W: begin
                    ow_reg <= cfg_data;
                end
                imtc_pkg::REG_OUT_B: begin
                    ob_reg <= cfg_data[15:0];
                end
                default: begin
                    // index off the end of the map: write dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline occupancy
    //   a: lane products   b: hidden values
    //   c: output products d: result register (m_valid)
    // Each stage loads when it is empty or its word moves on.
    // ---------------------------------------------------------------
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg;
    logic v_a_next, v_b_next, v_c_next, v_d_next;
    logic move_ab, move_bc, move_cd;
    logic ready_a, ready_b, ready_c, ready_d;
    logic take_in;

    assign ready_d = !v_d_reg || m_ready;
    assign move_cd = v_c_reg && ready_d;
    assign ready_c = !v_c_reg || move_cd;
    assign move_bc = v_b_reg && ready_c;
    assign ready_b = !v_b_reg || move_bc;
    assign move_ab = v_a_reg && ready_b;
    assign ready_a = !v_a_reg || move_ab;
    assign take_in = s_valid && ready_a;

    always_comb begin
        v_a_next = take_in || (v_a_reg && !move_ab);
        v_b_next = move_ab || (v_b_reg && !move_bc);
        v_c_next = move_bc || (v_c_reg && !move_cd);
        v_d_next = move_cd || (v_d_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end else begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
            v_d_reg <= v_d_next;
        end
    end

    assign s_ready = ready_a;
    assign m_valid = v_d_reg;

    // ---------------------------------------------------------------
    // Hidden lanes, one per hidden unit
    // ---------------------------------------------------------------
    imtc_pkg::feat_t [imtc_pkg::FEATURES-1:0] feats;
    imtc_pkg::hid_t  [imtc_pkg::HIDDEN-1:0]   hidden;
    imtc_pkg::lane_ctl_t                      lane_ctl;
    imtc_pkg::merge_ctl_t                     merge_ctl;

    assign feats[0] = s_feature_0;
    assign feats[1] = s_feature_1;
    assign feats[2] = s_feature_2;
    assign feats[3] = s_feature_3;
    assign feats[4] = s_feature_4;
    assign feats[5] = s_feature_5;

    assign lane_ctl.en_prod  = take_in;
    assign lane_ctl.en_sum   = move_ab;
    assign merge_ctl.en_prod = move_bc;
    assign merge_ctl.en_sum  = move_cd;

    for (genvar g = 0; g < imtc_pkg::HIDDEN; g++) begin : g_lane
        imtc_lane u_lane (
            .aclk          (aclk),
            .ctl           (lane_ctl),
            .features      (feats),
            .feature_count (s_feature_count),
            .weights       (hw_reg[g]),
            .bias          (hb_reg[8*g +: 8]),
            .hidden        (hidden[g])
        );
    end

    // ---------------------------------------------------------------
    // Output layer and class decision
    // ---------------------------------------------------------------
    imtc_merge u_merge (
        .aclk          (aclk),
        .ctl           (merge_ctl),
        .hidden        (hidden),
        .out_weights   (ow_reg),
        .out_biases    (ob_reg),
        .action        (m_action),
        .normal_logit  (m_normal_logit),
        .anomaly_logit (m_anomaly_logit)
    );

endmodule
`default_nettype wire

[sv/imtc_checker.sv]
// Port-level checks for the classifier, bound to the top level.
`default_nettype none
module imtc_checker (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic                    m_action,
    input wire imtc_pkg::logit_t        m_normal_logit,
    input wire imtc_pkg::logit_t        m_anomaly_logit
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid straight after reset");

    // decision agrees with the logits shown beside it, tie to normal
    a_argmax: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action == (m_anomaly_logit > m_normal_logit)))
        else $error("action disagrees with logits");

    // an empty result register means nothing can be holding the input back
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with result register empty");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action)
            && $stable(m_normal_logit) && $stable(m_anomaly_logit))
        else $error("result word changed while stalled");

endmodule

bind int8_mlp_two_class_classifier imtc_checker u_imtc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_action        (m_action),
    .m_normal_logit  (m_normal_logit),
    .m_anomaly_logit (m_anomaly_logit)
);
`default_nettype wire

[verif/int8_mlp_two_class_classifier_tb.sv]
// Self-checking testbench: random and directed embeddings against a predicted MLP verdict stream.
module int8_mlp_two_class_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imtc_pkg::*;

    // Input-to-result latency of the top level, plus some slack.
    localparam int PIPE_LATENCY   = 3;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int NUM_REGS       = 7;
    localparam int REPORT_LIMIT   = 10;
    localparam int RAND_PHASES    = 8;
    localparam int WORDS_PER_PASS = 200;
    localparam int MAX_COUNT      = (1 << COUNT_W) - 1;
    // Index past the register list: the block must drop the write.
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 3'd7;

    localparam logic [FEAT_W-1:0] FEAT_MAX = 8'h7F;
    localparam logic [FEAT_W-1:0] FEAT_MIN = 8'h80;

    typedef enum int {
        PLAN_TIE,           // output weights and biases zeroed: logits tie
        PLAN_ANOMALY_BIAS,  // anomaly bias one above normal, weights still zero
        PLAN_ALL_MIN,       // every byte -128
        PLAN_ALL_MAX,       // every byte +127
        PLAN_RANDOM
    } cfg_plan_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [HW_W-1:0]    feats;
    } embedding_t;

    typedef struct packed {
        logic   action;
        logit_t normal;
        logit_t anomaly;
    } verdict_t;

    // Every input is known from time zero.
    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    feat_t                s_feature_0     = '0;
    feat_t                s_feature_1     = '0;
    feat_t                s_feature_2     = '0;
    feat_t                s_feature_3     = '0;
    feat_t                s_feature_4     = '0;
    feat_t                s_feature_5     = '0;
    logic [COUNT_W-1:0]   s_feature_count = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_action;
    logit_t               m_normal_logit;
    logit_t               m_anomaly_logit;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [CFG_W-1:0]     cfg_data        = '0;

    // Our copy of the weight registers, updated at each accepted write to a mapped index.
    logic [CFG_W-1:0] weights_shadow [NUM_REGS];
    embedding_t       pending_words [$];
    verdict_t         expected_verdicts [$];
    int               src_gap_pct    = 10;
    int               sink_stall_pct = 86;
    int               mismatches     = 0;

    int8_mlp_two_class_classifier i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_feature_0     (s_feature_0),
        .s_feature_1     (s_feature_1),
        .s_feature_2     (s_feature_2),
        .s_feature_3     (s_feature_3),
        .s_feature_4     (s_feature_4),
        .s_feature_5     (s_feature_5),
        .s_feature_count (s_feature_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_normal_logit  (m_normal_logit),
        .m_anomaly_logit (m_anomaly_logit),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Signed byte idx of a packed register or feature vector.
    function automatic longint lane_byte(logic [CFG_W-1:0] packed_bytes, int idx);
        logic signed [FEAT_W-1:0] b;
        b = packed_bytes[idx*FEAT_W +: FEAT_W];
        return longint'(b);
    endfunction

    // Verdict for one embedding under the current shadow weights.
    function automatic verdict_t classify(embedding_t e);
        longint   acc;
        longint   hid [HIDDEN];
        longint   logit [LOGITS];
        int       used;
        verdict_t v;
        // a count past the number of features saturates: all features used
        used = (e.count > FEATURES) ? FEATURES : int'(e.count);
        for (int h = 0; h < HIDDEN; h++) begin
            acc = lane_byte(weights_shadow[REG_HIDDEN_B], h) * 16;
            for (int i = 0; i < used; i++)
                acc += lane_byte(weights_shadow[h], i) * lane_byte(CFG_W'(e.feats), i);
            hid[h] = (acc > 0) ? acc : 0;     // ReLU
        end
        for (int o = 0; o < LOGITS; o++) begin
            acc = lane_byte(weights_shadow[REG_OUT_B], o) * 256;
            for (int h = 0; h < HIDDEN; h++)
                acc += lane_byte(weights_shadow[REG_OUT_W], o * HIDDEN + h) * hid[h];
            logit[o] = acc;
        end
        // tie goes to normal
        v.action  = (logit[1] > logit[0]);
        v.normal  = logit[0][LOGIT_W-1:0];
        v.anomaly = logit[1][LOGIT_W-1:0];
        return v;
    endfunction

    function automatic embedding_t pack_word(logic [HW_W-1:0] feats, logic [COUNT_W-1:0] count);
        embedding_t e;
        e.feats = feats;
        e.count = count;
        return e;
    endfunction

    // Random features, leaning on the extremes now and then.
    function automatic logic [HW_W-1:0] rand_feats();
        logic [HW_W-1:0] f;
        for (int i = 0; i < FEATURES; i++) begin
            case ($urandom_range(0, 7))
                0:       f[i*FEAT_W +: FEAT_W] = FEAT_MAX;
                1:       f[i*FEAT_W +: FEAT_W] = FEAT_MIN;
                default: f[i*FEAT_W +: FEAT_W] = FEAT_W'($urandom_range(0, 255));
            endcase
        end
        return f;
    endfunction

    // Random register value; sometimes small bytes so more hidden units stay live.
    function automatic logic [CFG_W-1:0] rand_reg();
        logic [CFG_W-1:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < CFG_W / FEAT_W; i++)
                r[i*FEAT_W +: FEAT_W] = FEAT_W'($signed(r[i*FEAT_W +: 4]));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one word on the input channel at a time, held until taken.
    // A free slot is refilled in the same step, so valid never dips
    // between back-to-back words.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : word_driver
        embedding_t next_word;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_verdicts.push_back(classify(embedding_t'({s_feature_count,
                    s_feature_5, s_feature_4, s_feature_3,
                    s_feature_2, s_feature_1, s_feature_0})));
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    next_word       = pending_words.pop_front();
                    s_valid         <= 1'b1;
                    s_feature_0     <= next_word.feats[0*FEAT_W +: FEAT_W];
                    s_feature_1     <= next_word.feats[1*FEAT_W +: FEAT_W];
                    s_feature_2     <= next_word.feats[2*FEAT_W +: FEAT_W];
                    s_feature_3     <= next_word.feats[3*FEAT_W +: FEAT_W];
                    s_feature_4     <= next_word.feats[4*FEAT_W +: FEAT_W];
                    s_feature_5     <= next_word.feats[5*FEAT_W +: FEAT_W];
                    s_feature_count <= next_word.count;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, and every taken result word is
    // checked against the oldest expected verdict.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : verdict_monitor
        verdict_t want;
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with none expected: action %0d normal %0d anomaly %0d",
                             $realtime, m_action, m_normal_logit, m_anomaly_logit);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_action !== want.action || m_normal_logit !== want.normal ||
                    m_anomaly_logit !== want.anomaly) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch: action %0d/%0d normal %0d/%0d anomaly %0d/%0d (exp/got)",
                                 $realtime, want.action, m_action, want.normal, m_normal_logit,
                                 want.anomaly, m_anomaly_logit);
                end
            end
        end
    end

    // Return at a rising edge once the block has nothing in flight.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Called at a rising edge; returns at the edge that took the write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            weights_shadow[idx] = data;
    endtask

    task automatic reconfigure(cfg_plan_t plan);
        wait_idle();
        case (plan)
            PLAN_TIE: begin
                write_reg(REG_OUT_W, '0);
                write_reg(REG_OUT_B, '0);
            end
            PLAN_ANOMALY_BIAS: begin
                write_reg(REG_OUT_B, 64'h0100);
            end
            PLAN_ALL_MIN: begin
                for (int k = 0; k < NUM_REGS; k++)
                    write_reg(CFG_IDX_W'(k), {(CFG_W/FEAT_W){FEAT_MIN}});
            end
            PLAN_ALL_MAX: begin
                for (int k = 0; k < NUM_REGS; k++)
                    write_reg(CFG_IDX_W'(k), {(CFG_W/FEAT_W){FEAT_MAX}});
            end
            default: begin
                for (int k = 0; k < NUM_REGS; k++)
                    if ($urandom_range(0, 3) != 0)
                        write_reg(CFG_IDX_W'(k), rand_reg());
                write_reg(SPARE_IDX, rand_reg());
            end
        endcase
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed words on the trained defaults and on the
    // corner settings, then random passes on random weights.
    // Queue is only filled at falling edges, clear of the driver.
    // ------------------------------------------------------------------
    initial begin : stimulus
        weights_shadow[REG_HIDDEN0_W] = CFG_W'(HIDDEN0_W_RST);
        weights_shadow[REG_HIDDEN1_W] = CFG_W'(HIDDEN1_W_RST);
        weights_shadow[REG_HIDDEN2_W] = CFG_W'(HIDDEN2_W_RST);
        weights_shadow[REG_HIDDEN3_W] = CFG_W'(HIDDEN3_W_RST);
        weights_shadow[REG_HIDDEN_B]  = CFG_W'(HIDDEN_B_RST);
        weights_shadow[REG_OUT_W]     = CFG_W'(OUT_W_RST);
        weights_shadow[REG_OUT_B]     = CFG_W'(OUT_B_RST);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // trained defaults: field extremes, then every count incl. zero and saturated
        pending_words.push_back(pack_word('0, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({FEATURES{FEAT_MAX}}, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({FEATURES{FEAT_MIN}}, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({(FEATURES/2){FEAT_MIN, FEAT_MAX}}, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({(FEATURES/2){FEAT_MAX, FEAT_MIN}}, COUNT_W'(FEATURES)));
        for (int c = 0; c <= MAX_COUNT; c++)
            pending_words.push_back(pack_word(rand_feats(), COUNT_W'(c)));

        // equal logits must pick normal
        reconfigure(PLAN_TIE);
        pending_words.push_back(pack_word(rand_feats(), COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({FEATURES{FEAT_MAX}}, '0));

        // anomaly strictly ahead by its bias alone
        reconfigure(PLAN_ANOMALY_BIAS);
        pending_words.push_back(pack_word(rand_feats(), COUNT_W'(FEATURES)));

        // largest-magnitude weights both ways
        reconfigure(PLAN_ALL_MIN);
        pending_words.push_back(pack_word({FEATURES{FEAT_MIN}}, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({FEATURES{FEAT_MAX}}, COUNT_W'(MAX_COUNT)));
        pending_words.push_back(pack_word('0, '0));
        reconfigure(PLAN_ALL_MAX);
        pending_words.push_back(pack_word({FEATURES{FEAT_MAX}}, COUNT_W'(FEATURES)));
        pending_words.push_back(pack_word({FEATURES{FEAT_MIN}}, COUNT_W'(MAX_COUNT)));
        pending_words.push_back(pack_word('0, '0));

        // random passes; idling swaps sides, then stops altogether
        for (int p = 0; p < RAND_PHASES; p++) begin
            reconfigure(PLAN_RANDOM);
            if (p == 3) begin
                src_gap_pct    = 86;
                sink_stall_pct = 10;
            end else if (p == 6) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            repeat (WORDS_PER_PASS)
                pending_words.push_back(pack_word(rand_feats(),
                                                  COUNT_W'($urandom_range(0, MAX_COUNT))));
        end

        wait_idle();
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("int8_mlp_two_class_classifier_tb: done, clean");
        end else begin
            $display("int8_mlp_two_class_classifier_tb: done, errors");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("int8_mlp_two_class_classifier_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
sv/imtc_pkg.sv
sv/imtc_lane.sv
sv/imtc_merge.sv
sv/int8_mlp_two_class_classifier.sv
sv/imtc_checker.sv
verif/int8_mlp_two_class_classifier_tb.sv
